// ----- rtl/smooth_number_nth_core_defines.svh -----
// Assertion macros for the smooth number core checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef SMOOTH_NUMBER_NTH_CORE_DEFINES_SVH
`define SMOOTH_NUMBER_NTH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SNN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SNN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/snn_pkg.sv -----
// Shared widths, constants and register codes for the smooth number core.
// No dependencies.
package snn_pkg;

    localparam int FACTOR_W  = 32;
    localparam int VALUE_W   = 64;
    localparam int INDEX_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int LANES     = 3;

    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR_A = 2'd0,
        CFG_FACTOR_B = 2'd1,
        CFG_FACTOR_C = 2'd2
    } cfg_reg_t;

endpackage

// ----- rtl/snn_queue.sv -----
// One queue store: simple dual-port memory, one write and one registered read.
// Depends on snn_pkg for the entry width.
module snn_queue
    import snn_pkg::*;
#(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/snn_mul.sv -----
// Shared 32x32 multiplier with a registered product.
// Depends on snn_pkg for operand widths.
module snn_mul
    import snn_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [FACTOR_W-1:0]   a,
    input  logic [FACTOR_W-1:0]   b,
    output logic [2*FACTOR_W-1:0] p
);

    logic [2*FACTOR_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (2*FACTOR_W)'(a) * (2*FACTOR_W)'(b);
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/smooth_number_nth_core.sv -----
// Top level of the smooth number core: sequencer, lane state, config registers.
// Depends on snn_pkg, snn_mul and snn_queue.
//
// Usage:
//   Request: drive index and pulse start while busy is low; the request is
//   taken at that edge. index 0 is read as 1, an index above MAX_INDEX as
//   MAX_INDEX. The answer is the index-th number whose only factors are
//   factor_a, factor_b and factor_c, counting 1 as the first.
//   Result: value and overflow are shown for the single cycle in which done
//   is high. overflow is set when value is all ones (the saturation mark).
//   The receiver cannot stall; the result is gone after that cycle.
//   Sequence: after the accepting edge the core loads the seeds, then runs
//   n-1 generation steps for effective index n before done. Each step: two
//   compares for the minimum, three products of two passes each through the
//   one 32x32 multiplier plus a combine-and-push step, a pop step and a
//   head refill from the queue memories. busy stays high through done, so
//   the next request is taken in the cycle after done at the earliest.
//   Config: cfg_valid/cfg_ready write factor registers 0..2 while idle;
//   other indexes are dropped.
//   Reset: factors return to 2, 3, 5; the sequencer goes idle. Queue
//   memories are not cleared; every request reseeds them.
module smooth_number_nth_core
    import snn_pkg::*;
#(
    parameter int MAX_INDEX = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [INDEX_W-1:0]   index,
    output logic                 done,
    output logic [VALUE_W-1:0]   value,
    output logic                 overflow,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FACTOR_W-1:0]  cfg_data
);

    localparam int PTR_W = $clog2(MAX_INDEX);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_INDEX - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LOAD   = 10'b00_0000_0010,
        S_MIN1   = 10'b00_0000_0100,
        S_MIN2   = 10'b00_0000_1000,
        S_MUL_LO = 10'b00_0001_0000,
        S_MUL_HI = 10'b00_0010_0000,
        S_SUM    = 10'b00_0100_0000,
        S_POP    = 10'b00_1000_0000,
        S_REFILL = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [FACTOR_W-1:0] factor_reg [LANES];
    logic [PTR_W-1:0]    head_reg   [LANES];
    logic [PTR_W-1:0]    head_next  [LANES];
    logic [PTR_W-1:0]    tail_reg   [LANES];
    logic [PTR_W-1:0]    tail_next  [LANES];
    logic [VALUE_W-1:0]  hv_reg     [LANES];
    logic [VALUE_W-1:0]  hv_next    [LANES];
    logic [LANES-1:0]    pop_reg, pop_next;
    logic [1:0]          lane_reg, lane_next;
    logic [PTR_W-1:0]    remain_reg, remain_next;
    logic [VALUE_W-1:0]  m_reg, m_next;
    logic [VALUE_W-1:0]  lo_reg, lo_next;

    logic                q_we    [LANES];
    logic [PTR_W-1:0]    q_waddr [LANES];
    logic [VALUE_W-1:0]  q_wdata [LANES];
    logic                q_re    [LANES];
    logic [PTR_W-1:0]    q_raddr [LANES];
    logic [VALUE_W-1:0]  q_rdata [LANES];

    logic                  mul_en;
    logic [FACTOR_W-1:0]   mul_a;
    logic [FACTOR_W-1:0]   mul_b;
    logic [2*FACTOR_W-1:0] mul_p;

    logic [FACTOR_W:0]   mid_sum;
    logic                prod_ovf;
    logic [VALUE_W-1:0]  prod_sat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Shared multiplier: low half of m first, then high half, same factor.
    assign mul_en = (state_reg == S_MUL_LO) || (state_reg == S_MUL_HI);
    assign mul_a  = (state_reg == S_MUL_HI) ? m_reg[VALUE_W-1:FACTOR_W]
                                            : m_reg[FACTOR_W-1:0];
    assign mul_b  = factor_reg[lane_reg];

    snn_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Combine partial products: hi*2^32 + lo, saturate past 64 bits.
    assign mid_sum  = {1'b0, mul_p[FACTOR_W-1:0]} + {1'b0, lo_reg[VALUE_W-1:FACTOR_W]};
    assign prod_ovf = (|mul_p[2*FACTOR_W-1:FACTOR_W]) || mid_sum[FACTOR_W];
    assign prod_sat = prod_ovf ? ALL_ONES : {mid_sum[FACTOR_W-1:0], lo_reg[FACTOR_W-1:0]};

    for (genvar g = 0; g < LANES; g++)
    begin : g_queue
        snn_queue #(
            .DEPTH (MAX_INDEX)
        ) u_queue (
            .clk   (clk),
            .we    (q_we[g]),
            .waddr (q_waddr[g]),
            .wdata (q_wdata[g]),
            .re    (q_re[g]),
            .raddr (q_raddr[g]),
            .rdata (q_rdata[g])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        pop_next    = pop_reg;
        lane_next   = lane_reg;
        remain_next = remain_reg;
        m_next      = m_reg;
        lo_next     = lo_reg;
        for (int k = 0; k < LANES; k++)
        begin
            head_next[k] = head_reg[k];
            tail_next[k] = tail_reg[k];
            hv_next[k]   = hv_reg[k];
            q_we[k]      = 1'b0;
            q_waddr[k]   = tail_reg[k];
            q_wdata[k]   = prod_sat;
            q_re[k]      = 1'b0;
            q_raddr[k]   = ptr_inc(head_reg[k]);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (index == '0)
                    begin
                        remain_next = '0;
                    end
                    else if (32'(index) > 32'(MAX_INDEX))
                    begin
                        remain_next = PTR_LAST;
                    end
                    else
                    begin
                        remain_next = PTR_W'(index - INDEX_W'(1));
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // Seed each queue with its own factor.
                for (int k = 0; k < LANES; k++)
                begin
                    q_we[k]      = 1'b1;
                    q_waddr[k]   = '0;
                    q_wdata[k]   = VALUE_W'(factor_reg[k]);
                    hv_next[k]   = VALUE_W'(factor_reg[k]);
                    head_next[k] = '0;
                    tail_next[k] = ptr_inc('0);
                end
                m_next     = VALUE_W'(1);
                lane_next  = '0;
                state_next = (remain_reg == '0) ? S_DONE : S_MIN1;
            end
            S_MIN1:
            begin
                m_next     = (hv_reg[0] < hv_reg[1]) ? hv_reg[0] : hv_reg[1];
                state_next = S_MIN2;
            end
            S_MIN2:
            begin
                if (hv_reg[2] < m_reg)
                begin
                    m_next = hv_reg[2];
                end
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                lo_next    = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                q_we[lane_reg]      = 1'b1;
                tail_next[lane_reg] = ptr_inc(tail_reg[lane_reg]);
                if (lane_reg == 2'(LANES - 1))
                begin
                    lane_next  = '0;
                    state_next = S_POP;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_MUL_LO;
                end
            end
            S_POP:
            begin
                // Drop every head equal to the minimum and fetch the next one.
                for (int k = 0; k < LANES; k++)
                begin
                    pop_next[k] = (hv_reg[k] == m_reg);
                    if (hv_reg[k] == m_reg)
                    begin
                        q_re[k]      = 1'b1;
                        head_next[k] = ptr_inc(head_reg[k]);
                    end
                end
                state_next = S_REFILL;
            end
            S_REFILL:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    if (pop_reg[k])
                    begin
                        hv_next[k] = q_rdata[k];
                    end
                end
                remain_next = remain_reg - PTR_W'(1);
                state_next  = (remain_reg == PTR_W'(1)) ? S_DONE : S_MIN1;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lane_reg   <= '0;
            remain_reg <= '0;
            pop_reg    <= '0;
            for (int k = 0; k < LANES; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            lane_reg   <= lane_next;
            remain_reg <= remain_next;
            pop_reg    <= pop_next;
            for (int k = 0; k < LANES; k++)
            begin
                head_reg[k] <= head_next[k];
                tail_reg[k] <= tail_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg  <= m_next;
        lo_reg <= lo_next;
        for (int k = 0; k < LANES; k++)
        begin
            hv_reg[k] <= hv_next[k];
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg[0] <= FACTOR_W'(2);
            factor_reg[1] <= FACTOR_W'(3);
            factor_reg[2] <= FACTOR_W'(5);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FACTOR_A: factor_reg[0] <= cfg_data;
                CFG_FACTOR_B: factor_reg[1] <= cfg_data;
                CFG_FACTOR_C: factor_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign value    = m_reg;
    assign overflow = (m_reg == ALL_ONES);

endmodule

// ----- rtl/snn_monitor.sv -----
// Port-level checks for the smooth number core, bound to the top level.
// Depends on snn_pkg and smooth_number_nth_core_defines.svh.
`include "smooth_number_nth_core_defines.svh"

module snn_monitor
    import snn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [VALUE_W-1:0]   value,
    input logic                 overflow,
    input logic                 cfg_ready
);

    `SNN_ASSERT_NEXT(a_req_sets_busy, start && !busy, busy && !done)
    `SNN_ASSERT_NEXT(a_done_single, done, !done && !busy)
    `SNN_ASSERT_NOW(a_done_while_busy, done, busy && !cfg_ready)
    `SNN_ASSERT_NOW(a_ovf_mark, done, overflow == (value == ALL_ONES))

endmodule

bind smooth_number_nth_core snn_monitor u_snn_monitor (.*);

// ----- tb/smooth_number_checker.sv -----
// Checker for smooth_number_nth_core: watches the request, result and config channels,
// predicts each n-th smooth number and compares it with the value and overflow flag returned.
// Depends on snn_pkg.
module smooth_number_checker
    import snn_pkg::*;
#(
    parameter int MAX_INDEX = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [INDEX_W-1:0]   index,
    input  logic                 done,
    input  logic [VALUE_W-1:0]   value,
    input  logic                 overflow,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FACTOR_W-1:0]  cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } nth_result_t;

    logic [FACTOR_W-1:0] factor_set [LANES];
    nth_result_t         awaited_q [$];

    // Three ascending lanes, each seeded with its own factor; every step takes the
    // smallest head, appends its multiples and drops every head equal to it.
    function automatic nth_result_t nth_member(input logic [INDEX_W-1:0] idx);
        logic [VALUE_W-1:0]          lane_q [LANES][$];
        logic [VALUE_W+FACTOR_W-1:0] product;
        logic [VALUE_W-1:0]          least;
        int                          steps;
        nth_result_t                 res;
        steps = (idx == 0) ? 1 : (idx > MAX_INDEX) ? MAX_INDEX : int'(idx);
        least = 1;
        for (int k = 0; k < LANES; k++)
            lane_q[k].push_back(VALUE_W'(factor_set[k]));
        for (int n = 1; n < steps; n++)
        begin
            least = lane_q[0][0];
            for (int k = 1; k < LANES; k++)
                if (lane_q[k][0] < least)
                    least = lane_q[k][0];
            for (int k = 0; k < LANES; k++)
            begin
                product = least * factor_set[k];
                // saturate anything past 64 bits to all ones
                lane_q[k].push_back((product[VALUE_W+FACTOR_W-1:VALUE_W] != 0) ?
                                    ALL_ONES : product[VALUE_W-1:0]);
            end
            for (int k = 0; k < LANES; k++)
                if (lane_q[k][0] == least)
                    void'(lane_q[k].pop_front());
        end
        res.index    = idx;
        res.value    = least;
        res.overflow = (least == ALL_ONES);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nth_result_t want;
        int          errs;
        if (!rst_n)
        begin
            factor_set[0] <= 32'd2;
            factor_set[1] <= 32'd3;
            factor_set[2] <= 32'd5;
            awaited_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FACTOR_A: factor_set[0] <= cfg_data;
                    CFG_FACTOR_B: factor_set[1] <= cfg_data;
                    CFG_FACTOR_C: factor_set[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                awaited_q.push_back(nth_member(index));
            if (done)
            begin
                if (awaited_q.size() == 0)
                begin
                    $display("%0t: result with no request pending: %s %h overflow %b",
                             $time, "expected none, got value", value, overflow);
                    errs++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (value !== want.value)
                    begin
                        $display("%0t: index %0d value: expected %h, got %h",
                                 $time, want.index, want.value, value);
                        errs++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $display("%0t: index %0d overflow: expected %b, got %b",
                                 $time, want.index, want.overflow, overflow);
                        errs++;
                    end
                    checked <= checked + 1;
                end
            end
            mismatches  <= mismatches + errs;
            outstanding <= awaited_q.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the smooth_number_nth_core testbench: clock, reset, request and config stimulus.
// Depends on snn_pkg, smooth_number_nth_core and smooth_number_checker.
module testbench
    import snn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   MAX_INDEX  = 4096;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [FACTOR_W-1:0]  FACTOR_MAX = '1;
    localparam int                   RANDOM_PHASES  = 5;
    localparam int                   PHASE_REQUESTS = 16;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    logic [INDEX_W-1:0]   index     = '0;
    logic                 done;
    logic [VALUE_W-1:0]   value;
    logic                 overflow;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FACTOR_W-1:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;
    int checked;
    int requests      = 0;
    int settings_used = 0;

    smooth_number_nth_core #(
        .MAX_INDEX (MAX_INDEX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .index     (index),
        .done      (done),
        .value     (value),
        .overflow  (overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    smooth_number_checker #(
        .MAX_INDEX (MAX_INDEX)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .index       (index),
        .done        (done),
        .value       (value),
        .overflow    (overflow),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #250_000_000;
        $display("Timeout with %0d results still outstanding", outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Mostly short sequences; now and then a long one or a full 13-bit index.
    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 49);
        if (r == 0)
            return INDEX_W'($urandom);
        if (r == 1)
            return '0;
        if (r < 6)
            return INDEX_W'($urandom_range(65, 600));
        return INDEX_W'($urandom_range(1, 64));
    endfunction

    function automatic logic [FACTOR_W-1:0] pick_factor();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return FACTOR_W'($urandom_range(0, 1));
        if (r == 1)
            return FACTOR_MAX;
        if (r == 2)
            return FACTOR_W'($urandom);
        if (r < 6)
            return FACTOR_W'($urandom_range(2, 1000));
        return FACTOR_W'($urandom_range(2, 31));
    endfunction

    // Hold start until the request is taken; keep it high when no gap follows.
    task automatic issue_request(input logic [INDEX_W-1:0] idx, input int gap);
        start <= 1'b1;
        index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic program_factors(input logic [FACTOR_W-1:0] fa, input logic [FACTOR_W-1:0] fb,
                                   input logic [FACTOR_W-1:0] fc, input bit poke_unused);
        logic [FACTOR_W-1:0]  data    [4];
        logic [CFG_IDX_W-1:0] reg_sel [4];
        int                   first;
        data[0] = $urandom;
        data[1] = fa;
        data[2] = fb;
        data[3] = fc;
        reg_sel[0] = CFG_UNUSED;
        reg_sel[1] = CFG_FACTOR_A;
        reg_sel[2] = CFG_FACTOR_B;
        reg_sel[3] = CFG_FACTOR_C;
        first = poke_unused ? 0 : 1;
        cfg_valid <= 1'b1;
        for (int i = first; i < 4; i++)
        begin
            cfg_index <= reg_sel[i];
            cfg_data  <= data[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [INDEX_W-1:0]  reset_walk [7];
        logic [FACTOR_W-1:0] walk_factors [4][3];
        logic [INDEX_W-1:0]  walk_index [4][3];
        bit                  quiet;
        reset_walk   = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd7, 13'd4096, 13'd8191};
        // lowest factors; 2^64-1 built exactly from (2^32-1)*641*6700417;
        // all-ones factors whose cube saturates; zero and unit factors
        walk_factors = '{'{32'd2, 32'd2, 32'd2},
                         '{FACTOR_MAX, 32'd641, 32'd6700417},
                         '{FACTOR_MAX, FACTOR_MAX, FACTOR_MAX},
                         '{32'd0, 32'd1, 32'd7}};
        walk_index   = '{'{13'd5, 13'd30, 13'd1},
                         '{13'd20, 13'd21, 13'd22},
                         '{13'd3, 13'd4, 13'd5},
                         '{13'd1, 13'd2, 13'd6}};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset factors 2, 3, 5 first
        foreach (reset_walk[i])
            issue_request(reset_walk[i], pick_gap());

        for (int s = 0; s < 4; s++)
        begin
            drain_results();
            program_factors(walk_factors[s][0], walk_factors[s][1], walk_factors[s][2], s == 0);
            for (int i = 0; i < 3; i++)
                issue_request(walk_index[s][i], pick_gap());
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            program_factors(pick_factor(), pick_factor(), pick_factor(), p == 2);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                issue_request(pick_index(), quiet ? 0 : pick_gap());
                if (!quiet && $urandom_range(0, 11) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("Checked %0d results from %0d requests over %0d factor settings",
                 checked, requests, settings_used);
        $display("Settings spanned zero, unit and all-ones factors, %s",
                 "saturated and exact 2^64-1 values");
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
